// ===== design/gmdm_pkg.sv =====
// Shared constants and types for the grid masked depth mean block.
package gmdm_pkg;

  // Grid and cell geometry limits
  localparam int unsigned MAX_GRID_DIV = 8;
  localparam int unsigned MAX_CELL_DIM = 1024;
  localparam int unsigned NCELLS       = MAX_GRID_DIV * MAX_GRID_DIV;
  localparam int unsigned CELL_AW      = $clog2(NCELLS);

  // Field widths
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned DVD_W   = SUM_W + FRAC_W;
  localparam int unsigned STEP_W  = $clog2(DVD_W);
  localparam int unsigned ENTRY_W = SUM_W + CNT_W;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_DIV        = 3'd0,
    REG_CELL_WIDTH      = 3'd1,
    REG_CELL_HEIGHT     = 3'd2,
    REG_VALID_THRESHOLD = 3'd3,
    REG_FRAMES_NEEDED   = 3'd4
  } reg_index_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/grid_masked_depth_mean.sv =====
// Top level: pixel binning into grid cells, cell memory update and result sequencer.
// A pixel outside the grid or at or below the threshold is only taken in S_IDLE; a
// counted pixel also passes S_ACC, the read-modify-write of the cell memory (registered
// read). At frame end each cell passes memory read, a 44-step run of the shared divider
// and output load, which waits on output back-pressure; input waits for the last load.
// Reset (rst_n synchronous, low) loads register defaults and clears cell valid flags,
// positions and frame counter at once; no memory clearing pass is needed.
module grid_masked_depth_mean
  import gmdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // pixel input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DEPTH_W-1:0] in_depth,
  input  logic               in_line_end,
  input  logic               in_frame_end,
  // cell results
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CELL_AW-1:0] out_cell_index,
  output logic [MEAN_W-1:0]  out_mean_depth,
  output logic               out_last_cell,
  output logic [9:0]         out_frame_number,
  output logic               out_measurement_done,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ACC    = 6'b000010,
    S_ERD    = 6'b000100,
    S_ESTART = 6'b001000,
    S_EWAIT  = 6'b010000,
    S_EOUT   = 6'b100000
  } state_t;

  // configuration registers
  logic [3:0]         grid_div_r;
  logic [10:0]        cell_w_r;
  logic [10:0]        cell_h_r;
  logic [DEPTH_W-1:0] thresh_r;
  logic [9:0]         frames_r;

  // control state
  state_t             state_r;
  logic [9:0]         x_r;
  logic [3:0]         col_r;
  logic [9:0]         y_r;
  logic [3:0]         row_r;
  logic [9:0]         frame_cnt_r;
  logic [NCELLS-1:0]  cell_vld_r;
  logic [CELL_AW-1:0] k_r;
  logic               out_valid_r;

  // payload registers
  logic [DEPTH_W-1:0] depth_r;
  logic [CELL_AW-1:0] widx_r;
  logic               fend_r;
  logic               vld_q_r;
  logic               zero_r;
  logic [9:0]         fnum_r;
  logic               done_r;
  logic [CELL_AW-1:0] out_idx_r;
  logic [MEAN_W-1:0]  out_mean_r;
  logic               out_last_r;
  logic [9:0]         out_fnum_r;
  logic               out_done_r;

  // next values
  logic [9:0]         x_nxt;
  logic [3:0]         col_nxt;
  logic [9:0]         y_nxt;
  logic [3:0]         row_nxt;

  logic [3:0]         div_c;
  logic [10:0]        cw_c;
  logic [10:0]        ch_c;
  logic [9:0]         needed_c;
  logic [6:0]         total;
  logic               in_grid;
  logic [CELL_AW-1:0] cur_idx;
  logic               hit;
  logic               accept;
  logic               cfg_wr;
  logic [9:0]         fnum;
  logic               fdone;
  logic               last_k;
  logic               out_free;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [SUM_W-1:0]   old_sum;
  logic [CNT_W-1:0]   old_cnt;

  logic               div_start;
  logic [MEAN_W-1:0]  div_quo;
  div_stat_t          div_st;

  // clamp the geometry and frame count registers to their legal ranges
  always_comb begin
    if (grid_div_r == '0) begin
      div_c = 4'd1;
    end else if (grid_div_r > 4'(MAX_GRID_DIV)) begin
      div_c = 4'(MAX_GRID_DIV);
    end else begin
      div_c = grid_div_r;
    end
    if (cell_w_r == '0) begin
      cw_c = 11'd1;
    end else if (cell_w_r > 11'(MAX_CELL_DIM)) begin
      cw_c = 11'(MAX_CELL_DIM);
    end else begin
      cw_c = cell_w_r;
    end
    if (cell_h_r == '0) begin
      ch_c = 11'd1;
    end else if (cell_h_r > 11'(MAX_CELL_DIM)) begin
      ch_c = 11'(MAX_CELL_DIM);
    end else begin
      ch_c = cell_h_r;
    end
    needed_c = (frames_r == '0) ? 10'd1 : frames_r;
    total    = {3'b000, div_c} * {3'b000, div_c};
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_div_r <= 4'd7;
      cell_w_r   <= 11'd91;
      cell_h_r   <= 11'd68;
      thresh_r   <= 16'd10;
      frames_r   <= 10'd100;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GRID_DIV:        grid_div_r <= pwdata[3:0];
        REG_CELL_WIDTH:      cell_w_r   <= pwdata[10:0];
        REG_CELL_HEIGHT:     cell_h_r   <= pwdata[10:0];
        REG_VALID_THRESHOLD: thresh_r   <= pwdata[15:0];
        REG_FRAMES_NEEDED:   frames_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GRID_DIV:        prdata = {28'd0, grid_div_r};
      REG_CELL_WIDTH:      prdata = {21'd0, cell_w_r};
      REG_CELL_HEIGHT:     prdata = {21'd0, cell_h_r};
      REG_VALID_THRESHOLD: prdata = {16'd0, thresh_r};
      REG_FRAMES_NEEDED:   prdata = {22'd0, frames_r};
      default:             prdata = '0;
    endcase
  end

  // cell of the current pixel
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign in_grid  = (row_r < div_c) && (col_r < div_c);
  assign cur_idx  = CELL_AW'({3'b000, row_r} * {3'b000, div_c} + {3'b000, col_r});
  assign hit      = in_grid && (in_depth > thresh_r);

  // raster position update
  always_comb begin
    x_nxt   = x_r;
    col_nxt = col_r;
    y_nxt   = y_r;
    row_nxt = row_r;
    if (col_r < div_c) begin
      if ({1'b0, x_r} + 11'd1 >= cw_c) begin
        x_nxt   = '0;
        col_nxt = col_r + 4'd1;
      end else begin
        x_nxt = x_r + 10'd1;
      end
    end
    if (in_line_end) begin
      x_nxt   = '0;
      col_nxt = '0;
      if (row_r < div_c) begin
        if ({1'b0, y_r} + 11'd1 >= ch_c) begin
          y_nxt   = '0;
          row_nxt = row_r + 4'd1;
        end else begin
          y_nxt = y_r + 10'd1;
        end
      end
    end
    if (in_frame_end) begin
      x_nxt   = '0;
      col_nxt = '0;
      y_nxt   = '0;
      row_nxt = '0;
    end
  end

  // frame numbering
  assign fnum  = frame_cnt_r + 10'd1;
  assign fdone = (fnum >= needed_c);

  // cell memory: {sum, count}
  assign ram_raddr = (state_r == S_IDLE) ? cur_idx : k_r;
  assign old_sum   = vld_q_r ? ram_rdata[ENTRY_W-1:CNT_W] : '0;
  assign old_cnt   = vld_q_r ? ram_rdata[CNT_W-1:0] : '0;
  assign ram_we    = (state_r == S_ACC);
  assign ram_wdata = {old_sum + {{(SUM_W-DEPTH_W){1'b0}}, depth_r}, old_cnt + CNT_W'(1)};

  gmdm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared divider for the cell means
  assign div_start = (state_r == S_ESTART);

  gmdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ram_rdata[ENTRY_W-1:CNT_W], FRAC_W'(0)}),
    .divisor  (ram_rdata[CNT_W-1:0]),
    .quotient (div_quo),
    .stat     (div_st)
  );

  assign last_k   = ({1'b0, k_r} == (total - 7'd1));
  assign out_free = ~out_valid_r | out_ready;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      col_r       <= '0;
      y_r         <= '0;
      row_r       <= '0;
      frame_cnt_r <= '0;
      cell_vld_r  <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: set on a load, cleared once its transfer is taken
      if (state_r == S_EOUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r   <= x_nxt;
            col_r <= col_nxt;
            y_r   <= y_nxt;
            row_r <= row_nxt;
            k_r   <= '0;
            if (in_frame_end) begin
              frame_cnt_r <= fdone ? 10'd0 : fnum;
            end
            if (hit) begin
              state_r <= S_ACC;
            end else if (in_frame_end) begin
              state_r <= S_ERD;
            end
          end
        end
        S_ACC: begin
          cell_vld_r[widx_r] <= 1'b1;
          state_r <= fend_r ? S_ERD : S_IDLE;
        end
        S_ERD: begin
          state_r <= S_ESTART;
        end
        S_ESTART: begin
          state_r <= S_EWAIT;
        end
        S_EWAIT: begin
          if (div_st.done) begin
            state_r <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            if (last_k) begin
              cell_vld_r <= '0;
              state_r    <= S_IDLE;
            end else begin
              k_r     <= k_r + CELL_AW'(1);
              state_r <= S_ERD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vld_q_r <= cell_vld_r[ram_raddr];
    if (accept) begin
      depth_r <= in_depth;
      widx_r  <= cur_idx;
      fend_r  <= in_frame_end;
      if (in_frame_end) begin
        fnum_r <= fnum;
        done_r <= fdone;
      end
    end
    if (state_r == S_ESTART) begin
      zero_r <= ~vld_q_r | (ram_rdata[CNT_W-1:0] == '0);
    end
    if (state_r == S_EOUT && out_free) begin
      out_idx_r  <= k_r;
      out_mean_r <= zero_r ? '0 : div_quo;
      out_last_r <= last_k;
      out_fnum_r <= fnum_r;
      out_done_r <= done_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_cell_index       = out_idx_r;
  assign out_mean_depth       = out_mean_r;
  assign out_last_cell        = out_last_r;
  assign out_frame_number     = out_fnum_r;
  assign out_measurement_done = out_done_r;

`ifndef SYNTH
  // cell flags come out of reset all clear
  a_vld_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (cell_vld_r == '0))
    else $error("cell valid flags not cleared after reset");

  // the divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_EWAIT))
    else $error("divider done outside wait state");

  // the divider is never restarted while busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // the last-cell mark sits on the final cell of the grid
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ({1'b0, out_idx_r} == (total - 7'd1)))
    else $error("last cell mark on wrong cell");
`endif

endmodule

// ===== design/gmdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gmdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gmdm_div.sv =====
// Restoring divider, one quotient bit per cycle, keeps the low quotient bits.
module gmdm_div
  import gmdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [MEAN_W-1:0] quotient,
  output div_stat_t         stat
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  rem_r;
  logic [MEAN_W-1:0] quo_r;

  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    ge      = ~diff[CNT_W+1];
    rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[MEAN_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== tb/grid_masked_depth_mean_test.sv =====
// Testbench for grid_masked_depth_mean: pixel frames in, per-cell masked means checked.
module grid_masked_depth_mean_test
  import gmdm_pkg::*;
();

  // Delay after the last result before a register write or the end of the run
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 140;

  typedef struct packed {
    logic [CELL_AW-1:0] cell_index;
    logic [MEAN_W-1:0]  mean_depth;
    logic               last_cell;
    logic [9:0]         frame_number;
    logic               measurement_done;
  } cell_result_t;

  // Grid accumulator and expected cell means
  class depth_grid_scoreboard;
    logic [3:0]         grid_div;
    logic [10:0]        cell_width;
    logic [10:0]        cell_height;
    logic [15:0]        threshold;
    logic [9:0]         frames_needed;
    logic [SUM_W-1:0]   cell_sum [NCELLS];
    logic [CNT_W-1:0]   cell_cnt [NCELLS];
    int unsigned        px_x;
    int unsigned        col;
    int unsigned        line_y;
    int unsigned        row;
    logic [9:0]         frame_cnt;
    cell_result_t       expected_cells [$];
    int unsigned        errors;
    int unsigned        cells_checked;
    int unsigned        pixels_seen;
    int unsigned        frames_closed;
    int unsigned        done_frames;

    static function int unsigned fit_range(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void clear_frame();
      for (int k = 0; k < NCELLS; k++) begin
        cell_sum[k] = '0;
        cell_cnt[k] = '0;
      end
      px_x = 0;
      col = 0;
      line_y = 0;
      row = 0;
    endfunction

    function void reset_state();
      grid_div = 4'd7;
      cell_width = 11'd91;
      cell_height = 11'd68;
      threshold = 16'd10;
      frames_needed = 10'd100;
      frame_cnt = '0;
      errors = 0;
      cells_checked = 0;
      pixels_seen = 0;
      frames_closed = 0;
      done_frames = 0;
      expected_cells.delete();
      clear_frame();
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] v);
      case (idx)
        REG_GRID_DIV:        grid_div = v[3:0];
        REG_CELL_WIDTH:      cell_width = v[10:0];
        REG_CELL_HEIGHT:     cell_height = v[10:0];
        REG_VALID_THRESHOLD: threshold = v[15:0];
        REG_FRAMES_NEEDED:   frames_needed = v[9:0];
        default: ;
      endcase
    endfunction

    // One accepted pixel: accumulate, advance position, emit at frame end
    function void note_pixel(logic [15:0] depth, logic line_end, logic frame_end);
      int unsigned  div;
      int unsigned  cw;
      int unsigned  ch;
      int unsigned  idx;
      int unsigned  total;
      int unsigned  needed;
      logic [9:0]   fnum;
      logic         done;
      logic [SUM_W+FRAC_W-1:0] quot;
      cell_result_t r;
      div = fit_range(grid_div, MAX_GRID_DIV);
      cw = fit_range(cell_width, MAX_CELL_DIM);
      ch = fit_range(cell_height, MAX_CELL_DIM);
      pixels_seen++;
      if (row < div && col < div && depth > threshold) begin
        idx = (row * div + col) % NCELLS;
        cell_sum[idx] = cell_sum[idx] + depth;
        cell_cnt[idx] = cell_cnt[idx] + 1'b1;
      end
      if (col < div) begin
        px_x++;
        if (px_x >= cw) begin
          px_x = 0;
          col++;
        end
      end
      if (line_end) begin
        px_x = 0;
        col = 0;
        if (row < div) begin
          line_y++;
          if (line_y >= ch) begin
            line_y = 0;
            row++;
          end
        end
      end
      if (frame_end) begin
        needed = fit_range(frames_needed, 1023);
        fnum = frame_cnt + 10'd1;
        done = (fnum >= needed);
        total = div * div;
        for (int k = 0; k < total; k++) begin
          quot = '0;
          if (cell_cnt[k] != 0) quot = {cell_sum[k], {FRAC_W{1'b0}}} / cell_cnt[k];
          r.cell_index = k;
          r.mean_depth = quot[MEAN_W-1:0];
          r.last_cell = (k + 1 == total);
          r.frame_number = fnum;
          r.measurement_done = done;
          expected_cells.push_back(r);
        end
        frames_closed++;
        if (done) done_frames++;
        frame_cnt = done ? 10'd0 : fnum;
        clear_frame();
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one result transfer with the oldest expected cell
    task check_result(cell_result_t got);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected result for cell %0d", got.cell_index));
        return;
      end
      want = expected_cells.pop_front();
      cells_checked++;
      if (got.cell_index !== want.cell_index)
        report_mismatch($sformatf("cell_index got %0d want %0d",
                                  got.cell_index, want.cell_index));
      if (got.mean_depth !== want.mean_depth)
        report_mismatch($sformatf("cell %0d mean_depth got %h want %h",
                                  want.cell_index, got.mean_depth, want.mean_depth));
      if (got.last_cell !== want.last_cell)
        report_mismatch($sformatf("cell %0d last_cell got %b want %b",
                                  want.cell_index, got.last_cell, want.last_cell));
      if (got.frame_number !== want.frame_number)
        report_mismatch($sformatf("cell %0d frame_number got %0d want %0d",
                                  want.cell_index, got.frame_number, want.frame_number));
      if (got.measurement_done !== want.measurement_done)
        report_mismatch($sformatf("cell %0d measurement_done got %b want %b",
                                  want.cell_index, got.measurement_done,
                                  want.measurement_done));
    endtask
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [DEPTH_W-1:0] in_depth = '0;
  logic               in_line_end = 1'b0;
  logic               in_frame_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CELL_AW-1:0] out_cell_index;
  logic [MEAN_W-1:0]  out_mean_depth;
  logic               out_last_cell;
  logic [9:0]         out_frame_number;
  logic               out_measurement_done;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  depth_grid_scoreboard sb = new;
  int unsigned source_quiet = 0;
  int unsigned sink_quiet = 0;

  grid_masked_depth_mean dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_depth             (in_depth),
    .in_line_end          (in_line_end),
    .in_frame_end         (in_frame_end),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cell_index       (out_cell_index),
    .out_mean_depth       (out_mean_depth),
    .out_last_cell        (out_last_cell),
    .out_frame_number     (out_frame_number),
    .out_measurement_done (out_measurement_done),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #48000000;
    $display("TB_ERROR");
    $finish;
  end

  // Idle cycles before an item; runs of zero give stretches with no idling
  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Depth biased toward the threshold edges and the field extremes
  function automatic logic [15:0] pick_depth(logic [15:0] thr);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return thr;
      3: return thr + 16'd1;
      4: return thr - 16'd1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // One register write: setup phase, access phase, then the bus returns to idle
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [3:0] gd, logic [10:0] cw, logic [10:0] ch,
                           logic [15:0] thr, logic [9:0] fn);
    write_reg(REG_GRID_DIV, gd);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_VALID_THRESHOLD, thr);
    write_reg(REG_FRAMES_NEEDED, fn);
  endtask

  // Pixel transfer; valid stays high if the next pixel follows with no gap
  task automatic send_pixel(logic [15:0] d, logic le, logic fe);
    int unsigned gap;
    gap = draw_wait(source_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_depth <= d;
    in_line_end <= le;
    in_frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(d, le, fe);
  endtask

  // Stop the pixel stream and wait until every cell result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [3:0]  gd;
    logic [10:0] cw;
    logic [10:0] ch;
    logic [15:0] thr;
    logic [9:0]  fn;
    drain_results();
    case ($urandom_range(0, 9))
      0: gd = 4'd0;
      1: gd = 4'd15;
      2: gd = 4'd8;
      3: gd = $urandom_range(4, 14);
      default: gd = $urandom_range(1, 3);
    endcase
    case ($urandom_range(0, 19))
      0, 1: cw = 11'd0;
      2: cw = 11'd2047;
      default: cw = $urandom_range(1, 3);
    endcase
    case ($urandom_range(0, 19))
      0, 1: ch = 11'd0;
      2: ch = 11'd2047;
      default: ch = $urandom_range(1, 2);
    endcase
    case ($urandom_range(0, 5))
      0: thr = 16'd0;
      1: thr = 16'hFFFF;
      2: thr = 16'h8000;
      3: thr = $urandom_range(0, 1000);
      default: thr = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 6))
      0: fn = 10'd0;
      1: fn = 10'd1;
      2: fn = 10'd1023;
      3: fn = $urandom_range(1, 1023);
      default: fn = $urandom_range(2, 4);
    endcase
    if ($urandom_range(0, 1)) write_reg(REG_GRID_DIV, gd);
    if ($urandom_range(0, 1)) write_reg(REG_CELL_WIDTH, cw);
    if ($urandom_range(0, 1)) write_reg(REG_CELL_HEIGHT, ch);
    if ($urandom_range(0, 1)) write_reg(REG_VALID_THRESHOLD, thr);
    if ($urandom_range(0, 3) == 0) write_reg(REG_FRAMES_NEEDED, fn);
  endtask

  // Register change with a frame partly sent; takes effect on the next pixel
  task automatic mid_frame_change();
    drain_results();
    case ($urandom_range(0, 3))
      0: write_reg(REG_VALID_THRESHOLD, $urandom_range(0, 65535));
      1: write_reg(REG_GRID_DIV, $urandom_range(1, 4));
      2: write_reg(REG_CELL_WIDTH, $urandom_range(1, 3));
      default: write_reg(REG_CELL_HEIGHT, $urandom_range(1, 2));
    endcase
  endtask

  // Raster frame: whole cells plus a margin, sometimes cut short or split
  task automatic random_frame(bit force_split);
    int unsigned div;
    int unsigned width_px;
    int unsigned lines;
    int unsigned cap;
    int unsigned split_at;
    int unsigned count;
    int unsigned line_len;
    bit          long_line;
    bit          stop;
    bit          eol;
    logic        le;
    logic        fe;
    div = sb.fit_range(sb.grid_div, MAX_GRID_DIV);
    width_px = div * sb.fit_range(sb.cell_width, MAX_CELL_DIM) + $urandom_range(0, 2);
    lines = div * sb.fit_range(sb.cell_height, MAX_CELL_DIM) + $urandom_range(0, 1);
    cap = $urandom_range(4, 40);
    split_at = (force_split || $urandom_range(0, 5) == 0) ? $urandom_range(1, cap - 1) : 0;
    count = 0;
    stop = 0;
    for (int ln = 0; ln < lines && !stop; ln++) begin
      long_line = ($urandom_range(0, 9) == 0);
      line_len = width_px + (long_line ? 3 : 0);
      for (int p = 0; p < line_len && !stop; p++) begin
        count++;
        eol = (p == line_len - 1);
        le = eol && !long_line;
        if ($urandom_range(0, 29) == 0) le = ~le;
        fe = (count == cap) || (eol && ln == lines - 1);
        if (!fe && $urandom_range(0, 99) == 0) fe = 1'b1;
        send_pixel(pick_depth(sb.threshold), le, fe);
        if (fe) stop = 1;
        else if (count == split_at) mid_frame_change();
      end
    end
  endtask

  // Result sink with random back-pressure
  initial begin : result_sink
    int unsigned  stall;
    cell_result_t got;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.cell_index = out_cell_index;
      got.mean_depth = out_mean_depth;
      got.last_cell = out_last_cell;
      got.frame_number = out_frame_number;
      got.measurement_done = out_measurement_done;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned start_pixels;
    int unsigned frame_idx;
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 grid of 2x1 cells, margin column and line, threshold equality
    write_all(4'd2, 11'd2, 11'd1, 16'd100, 10'd2);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'd100, 1'b0, 1'b0);
    send_pixel(16'd101, 1'b0, 1'b0);
    send_pixel(16'd0, 1'b0, 1'b0);
    send_pixel(16'd7, 1'b1, 1'b0);
    send_pixel(16'd0, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'd200, 1'b0, 1'b0);
    send_pixel(16'd300, 1'b0, 1'b0);
    send_pixel(16'd400, 1'b1, 1'b0);
    send_pixel(16'd500, 1'b1, 1'b1);
    drain_results();

    // Line with no line end runs past the grid; frame ends mid-line, done raised
    send_pixel(16'd1000, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'd3000, 1'b0, 1'b0);
    send_pixel(16'd4000, 1'b0, 1'b0);
    send_pixel(16'd5000, 1'b0, 1'b0);
    send_pixel(16'd6000, 1'b0, 1'b0);
    send_pixel(16'd7000, 1'b0, 1'b1);
    drain_results();

    // Oversized settings clamp to the grid and cell limits
    write_all(4'd15, 11'd2047, 11'd2047, 16'd0, 10'd0);
    send_pixel(16'd1, 1'b1, 1'b1);
    drain_results();

    // Zero settings act as one; nothing exceeds the top threshold
    write_all(4'd0, 11'd0, 11'd0, 16'hFFFF, 10'd1023);
    send_pixel(16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b1);
    drain_results();

    // Random frames
    write_all(4'd2, 11'd2, 11'd2, 16'd1000, 10'd3);
    start_pixels = sb.pixels_seen;
    frame_idx = 0;
    while (sb.pixels_seen - start_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(0, 1)) random_config();
      random_frame(frame_idx == 0);
      frame_idx++;
      if ($urandom_range(0, 2) == 0) drain_results();
    end
    drain_results();
    repeat (40) @(posedge clk);

    $display("Run covered %0d pixels in %0d frames (%0d with done set), %0d cell results.",
             sb.pixels_seen, sb.frames_closed, sb.done_frames, sb.cells_checked);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gmdm_pkg.sv
design/gmdm_ram.sv
design/gmdm_div.sv
design/grid_masked_depth_mean.sv
tb/grid_masked_depth_mean_test.sv
